FILE: rtl/tlsc_pkg.sv
// tlsc_pkg: shared types, codes and constants of the timed locked session controller
// no dependencies; used by the top level, the assertion module, the checker and the testbench

package tlsc_pkg;

  localparam int unsigned CFG_AW = 4;

  // register indices (paddr[3:2])
  localparam logic [1:0] REG_LOCK_WAIT    = 2'd0;
  localparam logic [1:0] REG_UNLOCK_GRACE = 2'd1;
  localparam logic [1:0] REG_HANGUP_WAIT  = 2'd2;
  localparam logic [1:0] NUM_REGS         = 2'd3;

  localparam logic [31:0] LOCK_WAIT_RST    = 32'd60000;
  localparam logic [31:0] UNLOCK_GRACE_RST = 32'd30000;
  localparam logic [31:0] HANGUP_WAIT_RST  = 32'd10000;

  // item actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_CALL  = 2'd3;

  // result events
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_REPORT = 2'd1;
  localparam logic [1:0] EV_CALL   = 2'd2;
  localparam logic [1:0] EV_HANGUP = 2'd3;

  // indicator bits
  localparam int unsigned IND_GREEN  = 0;
  localparam int unsigned IND_ORANGE = 1;
  localparam int unsigned IND_RED    = 2;
  localparam int unsigned IND_OUT    = 3;

  localparam logic [31:0] MS_PER_MIN = 32'd60000;

  // x / 60000 == ((x >> 5) * DIV_MAGIC) >> DIV_SHIFT, exact for 32-bit x
  localparam int unsigned DIV_PRESHIFT = 5;
  localparam int unsigned DIV_SHIFT    = 38;
  localparam logic [27:0] DIV_MAGIC    = 28'd146601551;
  localparam int unsigned DIV_XW       = 32 - DIV_PRESHIFT;
  localparam int unsigned DIV_PW       = DIV_XW + 28;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_WAIT_LOCK = 5'b00010,
    PH_WORKING   = 5'b00100,
    PH_WAIT_CALL = 5'b01000,
    PH_HANGUP    = 5'b10000
  } phase_t;

  // result before the minute division
  typedef struct packed {
    logic [3:0]  ind;
    logic        busy;
    logic [1:0]  ev;
    logic [31:0] div_x;
    logic        div_rep;
  } pre_res_t;

  typedef struct packed {
    logic        output_enable;
    logic        led_green;
    logic        led_orange;
    logic        led_red;
    logic        busy_res;
    logic [15:0] minutes_left;
    logic [1:0]  event_res;
    logic [16:0] event_minutes;
  } res_t;

endpackage

FILE: rtl/tlsc_in_if.sv
// tlsc_in_if: input channel of the session controller, valid/ready with item fields
// no dependencies

interface tlsc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        lock_closed;
  logic [15:0] duration_min;
  logic        report_mode;
  logic        call_failed;

  modport source (output valid, action, lock_closed, duration_min, report_mode,
                  call_failed, input ready);
  modport sink (input valid, action, lock_closed, duration_min, report_mode,
                call_failed, output ready);
endinterface

FILE: rtl/tlsc_out_if.sv
// tlsc_out_if: result channel of the session controller, valid/ready with result fields
// no dependencies

interface tlsc_out_if;
  logic        valid;
  logic        ready;
  logic        output_enable;
  logic        led_green;
  logic        led_orange;
  logic        led_red;
  logic        busy_res;
  logic [15:0] minutes_left;
  logic [1:0]  event_res;
  logic [16:0] event_minutes;

  modport source (output valid, output_enable, led_green, led_orange, led_red, busy_res,
                  minutes_left, event_res, event_minutes, input ready);
  modport sink (input valid, output_enable, led_green, led_orange, led_red, busy_res,
                minutes_left, event_res, event_minutes, output ready);
endinterface

FILE: rtl/timed_locked_session_controller.sv
// timed_locked_session_controller: session timer with lock supervision and call events
// depends on tlsc_pkg, tlsc_in_if, tlsc_out_if
// an accepted beat is registered in s1_r after the state update, then in out_r after the
// minute division by reciprocal multiply; throughput one beat per cycle unless the result port stalls
// in_ch.ready falls only while both result stages hold beats and out_ch.ready is low
// rst_n (synchronous, active low) clears the session state and restores register defaults

module timed_locked_session_controller
  import tlsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tlsc_in_if.sink           in_ch,
  tlsc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  logic [31:0] lock_wait_r, unlock_grace_r, hangup_wait_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] pel_r, pel_nxt;
  logic [31:0] oel_r, oel_nxt;
  logic [15:0] smin_r, smin_nxt;
  logic        umode_r, umode_nxt;
  logic        stop_r, stop_nxt;
  logic        start_r, start_nxt;
  logic [3:0]  ind_r, ind_nxt;

  pre_res_t    pre_nxt, s1_r;
  logic        s1_v_r;
  res_t        res_nxt, out_r;
  logic        out_v_r;

  logic        in_acc, adv1, adv2, cfg_wr, go_on;
  logic [31:0] total;
  logic [DIV_PW-1:0] prod;
  logic [16:0] quot;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_wait_r    <= LOCK_WAIT_RST;
      unlock_grace_r <= UNLOCK_GRACE_RST;
      hangup_wait_r  <= HANGUP_WAIT_RST;
    end else if (cfg_wr) begin
      case (paddr[CFG_AW-1:2])
        REG_LOCK_WAIT:    lock_wait_r    <= pwdata;
        REG_UNLOCK_GRACE: unlock_grace_r <= pwdata;
        REG_HANGUP_WAIT:  hangup_wait_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_AW-1:2])
      REG_LOCK_WAIT:    prdata = lock_wait_r;
      REG_UNLOCK_GRACE: prdata = unlock_grace_r;
      REG_HANGUP_WAIT:  prdata = hangup_wait_r;
      default:          prdata = '0;
    endcase
  end

  // handshake
  assign adv2        = !out_v_r || out_ch.ready;
  assign adv1        = !s1_v_r || adv2;
  assign in_ch.ready = adv1;
  assign in_acc      = in_ch.valid && adv1;

  // session update for one beat
  always_comb begin
    phase_nxt = phase_r;
    pel_nxt   = pel_r;
    oel_nxt   = oel_r;
    smin_nxt  = smin_r;
    umode_nxt = umode_r;
    stop_nxt  = stop_r;
    start_nxt = start_r;
    ind_nxt   = ind_r;
    go_on     = 1'b0;
    pre_nxt   = '0;

    case (in_ch.action)
      ACT_START: begin
        smin_nxt  = in_ch.duration_min;
        umode_nxt = in_ch.report_mode;
        if (phase_r == PH_IDLE) begin
          start_nxt          = 1'b1;
          stop_nxt           = 1'b0;
          ind_nxt[IND_GREEN] = 1'b1;
          pel_nxt            = '0;
          phase_nxt          = PH_WAIT_LOCK;
        end
      end
      ACT_STOP: begin
        if (phase_r inside {PH_WAIT_LOCK, PH_WORKING}) stop_nxt = 1'b1;
      end
      ACT_TICK: begin
        if (phase_r inside {PH_WAIT_LOCK, PH_WORKING, PH_HANGUP}) pel_nxt = sat_inc(pel_r);
        if (phase_r == PH_WORKING) oel_nxt = sat_inc(oel_r);
      end
      ACT_CALL: begin
        if (phase_r == PH_WAIT_CALL) begin
          if (in_ch.call_failed) begin
            phase_nxt = PH_IDLE;
            start_nxt = 1'b0;
            stop_nxt  = 1'b0;
            ind_nxt   = '0;
          end else begin
            phase_nxt = PH_HANGUP;
            pel_nxt   = '0;
          end
        end
      end
      default: ;
    endcase

    total = {16'd0, smin_nxt} * MS_PER_MIN;

    if (phase_nxt == PH_WAIT_LOCK) begin
      if (stop_nxt || pel_nxt >= lock_wait_r) begin
        phase_nxt = PH_IDLE;
        start_nxt = 1'b0;
        stop_nxt  = 1'b0;
        ind_nxt   = '0;
      end else if (in_ch.lock_closed) begin
        ind_nxt[IND_ORANGE] = 1'b1;
        phase_nxt           = PH_WORKING;
        pel_nxt             = '0;
        oel_nxt             = '0;
      end
    end

    if (phase_nxt == PH_WORKING) begin
      if (!stop_nxt) begin
        if (in_ch.lock_closed) begin
          ind_nxt[IND_OUT] = 1'b1;
          ind_nxt[IND_RED] = 1'b1;
          oel_nxt          = '0;
        end else begin
          ind_nxt[IND_OUT] = 1'b0;
        end
        go_on = (pel_nxt < total) && (oel_nxt < unlock_grace_r);
      end
      if (!go_on) begin
        ind_nxt = '0;
        if (stop_nxt) begin
          phase_nxt = PH_IDLE;
          start_nxt = 1'b0;
          stop_nxt  = 1'b0;
        end else if (umode_nxt) begin
          pre_nxt.ev      = EV_REPORT;
          pre_nxt.div_rep = 1'b1;
          pre_nxt.div_x   = (pel_nxt > unlock_grace_r) ? pel_nxt - unlock_grace_r : '0;
          phase_nxt       = PH_IDLE;
          start_nxt       = 1'b0;
          stop_nxt        = 1'b0;
        end else begin
          pre_nxt.ev = EV_CALL;
          phase_nxt  = PH_WAIT_CALL;
        end
      end
    end

    if (phase_nxt == PH_HANGUP && pel_nxt >= hangup_wait_r) begin
      pre_nxt.ev = EV_HANGUP;
      phase_nxt  = PH_IDLE;
      start_nxt  = 1'b0;
      stop_nxt   = 1'b0;
      ind_nxt    = '0;
    end

    if (phase_nxt inside {PH_WAIT_LOCK, PH_WORKING}) begin
      pre_nxt.div_x = (total > pel_nxt) ? total - pel_nxt : '0;
    end

    pre_nxt.ind  = ind_nxt;
    pre_nxt.busy = start_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pel_r   <= '0;
      oel_r   <= '0;
      smin_r  <= '0;
      umode_r <= 1'b0;
      stop_r  <= 1'b0;
      start_r <= 1'b0;
      ind_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      pel_r   <= pel_nxt;
      oel_r   <= oel_nxt;
      smin_r  <= smin_nxt;
      umode_r <= umode_nxt;
      stop_r  <= stop_nxt;
      start_r <= start_nxt;
      ind_r   <= ind_nxt;
    end
  end

  // minute division
  assign prod = s1_r.div_x[31:DIV_PRESHIFT] * DIV_MAGIC;
  assign quot = prod[DIV_SHIFT +: 17];

  always_comb begin
    res_nxt.output_enable = s1_r.ind[IND_OUT];
    res_nxt.led_green     = s1_r.ind[IND_GREEN];
    res_nxt.led_orange    = s1_r.ind[IND_ORANGE];
    res_nxt.led_red       = s1_r.ind[IND_RED];
    res_nxt.busy_res      = s1_r.busy;
    res_nxt.event_res     = s1_r.ev;
    res_nxt.minutes_left  = s1_r.div_rep ? '0 : quot[15:0];
    res_nxt.event_minutes = s1_r.div_rep ? quot : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_acc;
      if (adv2) out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_r <= pre_nxt;
    if (adv2 && s1_v_r) out_r <= res_nxt;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.output_enable = out_r.output_enable;
  assign out_ch.led_green     = out_r.led_green;
  assign out_ch.led_orange    = out_r.led_orange;
  assign out_ch.led_red       = out_r.led_red;
  assign out_ch.busy_res      = out_r.busy_res;
  assign out_ch.minutes_left  = out_r.minutes_left;
  assign out_ch.event_res     = out_r.event_res;
  assign out_ch.event_minutes = out_r.event_minutes;

endmodule

FILE: rtl/tlsc_checker.sv
// tlsc_props: port-level assertions for the session controller, bound to the top level
// depends on tlsc_pkg and timed_locked_session_controller

module tlsc_props
  import tlsc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              output_enable,
  input logic              led_green,
  input logic              led_orange,
  input logic              led_red,
  input logic              busy_res,
  input logic [15:0]       minutes_left,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [CFG_AW-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_rst_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (out_ready || !out_valid) |=> out_valid)
    else $error("accepted beat did not reach the result port in two cycles");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[CFG_AW-1:2] < NUM_REGS)
      ##1 (psel && !pwrite && paddr == $past(paddr)) |-> prdata == $past(pwdata))
    else $error("register read does not return written value");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> !output_enable && !led_green && !led_orange && !led_red
                               && minutes_left == 16'd0)
    else $error("indicators or minutes shown without a session");

endmodule

bind timed_locked_session_controller tlsc_props u_tlsc_props (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .output_enable (out_ch.output_enable),
  .led_green     (out_ch.led_green),
  .led_orange    (out_ch.led_orange),
  .led_red       (out_ch.led_red),
  .busy_res      (out_ch.busy_res),
  .minutes_left  (out_ch.minutes_left),
  .psel          (psel),
  .penable       (penable),
  .pwrite        (pwrite),
  .paddr         (paddr),
  .pwdata        (pwdata),
  .prdata        (prdata)
);

FILE: tb/sv/tlsc_checker.sv
// tlsc_checker: watches the item, result and register ports of the session controller,
// keeps its own copy of the session state and compares every result beat with it
// depends on tlsc_pkg, tlsc_in_if and tlsc_out_if
module tlsc_checker
  import tlsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  tlsc_in_if                in_mon,
  tlsc_out_if               out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic [31:0]       prdata,
  input  logic              pready,
  output int                fail_cnt,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] lock_wait;
  logic [31:0] grace;
  logic [31:0] hang_wait;

  phase_t      ph;
  logic [31:0] ph_ms;
  logic [31:0] open_ms;
  logic [15:0] sess_min;
  logic        usage;
  logic        stop_pend;
  logic        started;
  logic [3:0]  ind;

  res_t        session_q[$];
  int          errs = 0;

  function automatic void flag(string msg);
    errs++;
    if (errs <= 10) $display("%s", msg);
  endfunction

  function automatic string show(res_t r);
    return $sformatf("oe=%0b g=%0b o=%0b r=%0b busy=%0b left=%0d ev=%0d min=%0d",
                     r.output_enable, r.led_green, r.led_orange, r.led_red, r.busy_res,
                     r.minutes_left, r.event_res, r.event_minutes);
  endfunction

  function automatic void close_session();
    ph        = PH_IDLE;
    started   = 1'b0;
    stop_pend = 1'b0;
    ind       = '0;
  endfunction

  function automatic res_t session_result(logic [1:0] act, logic lk, logic [15:0] dur,
                                          logic rep, logic fail);
    res_t        r;
    logic [1:0]  ev;
    logic [31:0] evm;
    logic [31:0] left;
    logic [31:0] total;
    logic        go_on;
    ev    = EV_NONE;
    evm   = '0;
    left  = '0;
    go_on = 1'b0;
    case (act)
      ACT_START: begin
        sess_min = dur;
        usage    = rep;
        if (ph == PH_IDLE) begin
          started        = 1'b1;
          stop_pend      = 1'b0;
          ind[IND_GREEN] = 1'b1;
          ph_ms          = '0;
          ph             = PH_WAIT_LOCK;
        end
      end
      ACT_STOP: begin
        if (ph == PH_WAIT_LOCK || ph == PH_WORKING) stop_pend = 1'b1;
      end
      ACT_TICK: begin
        if ((ph == PH_WAIT_LOCK || ph == PH_WORKING || ph == PH_HANGUP) && ph_ms != '1)
          ph_ms = ph_ms + 1;
        if (ph == PH_WORKING && open_ms != '1) open_ms = open_ms + 1;
      end
      default: begin
        if (ph == PH_WAIT_CALL) begin
          if (fail) begin
            close_session();
          end else begin
            ph    = PH_HANGUP;
            ph_ms = '0;
          end
        end
      end
    endcase
    total = sess_min * MS_PER_MIN;

    if (ph == PH_WAIT_LOCK) begin
      if (stop_pend || ph_ms >= lock_wait) begin
        close_session();
      end else if (lk) begin
        ind[IND_ORANGE] = 1'b1;
        ph              = PH_WORKING;
        ph_ms           = '0;
        open_ms         = '0;
      end
    end

    if (ph == PH_WORKING) begin
      if (!stop_pend) begin
        if (lk) begin
          ind[IND_OUT] = 1'b1;
          ind[IND_RED] = 1'b1;
          open_ms      = '0;
        end else begin
          ind[IND_OUT] = 1'b0;
        end
        go_on = (ph_ms < total) && (open_ms < grace);
      end
      if (!go_on) begin
        ind = '0;
        if (stop_pend) begin
          close_session();
        end else if (usage) begin
          ev  = EV_REPORT;
          evm = (ph_ms > grace) ? (ph_ms - grace) / MS_PER_MIN : '0;
          close_session();
        end else begin
          ev = EV_CALL;
          ph = PH_WAIT_CALL;
        end
      end
    end

    if (ph == PH_HANGUP && ph_ms >= hang_wait) begin
      ev = EV_HANGUP;
      close_session();
    end

    if ((ph == PH_WAIT_LOCK || ph == PH_WORKING) && total > ph_ms)
      left = (total - ph_ms) / MS_PER_MIN;

    r.output_enable = ind[IND_OUT];
    r.led_green     = ind[IND_GREEN];
    r.led_orange    = ind[IND_ORANGE];
    r.led_red       = ind[IND_RED];
    r.busy_res      = started;
    r.minutes_left  = left[15:0];
    r.event_res     = ev;
    r.event_minutes = evm[16:0];
    return r;
  endfunction

  always @(posedge clk) begin
    res_t        seen;
    res_t        want;
    logic [31:0] want_reg;
    if (!rst_n) begin
      lock_wait = LOCK_WAIT_RST;
      grace     = UNLOCK_GRACE_RST;
      hang_wait = HANGUP_WAIT_RST;
      ph        = PH_IDLE;
      ph_ms     = '0;
      open_ms   = '0;
      sess_min  = '0;
      usage     = 1'b0;
      stop_pend = 1'b0;
      started   = 1'b0;
      ind       = '0;
      session_q.delete();
    end else begin
      if (psel && penable && pready && pwrite) begin
        case (paddr[CFG_AW-1:2])
          REG_LOCK_WAIT:    lock_wait = pwdata;
          REG_UNLOCK_GRACE: grace     = pwdata;
          REG_HANGUP_WAIT:  hang_wait = pwdata;
          default: ;
        endcase
      end
      if (psel && penable && pready && !pwrite && paddr[CFG_AW-1:2] != NUM_REGS) begin
        case (paddr[CFG_AW-1:2])
          REG_LOCK_WAIT:    want_reg = lock_wait;
          REG_UNLOCK_GRACE: want_reg = grace;
          default:          want_reg = hang_wait;
        endcase
        if (prdata !== want_reg)
          flag($sformatf("register %0d read: exp %0d got %0d",
                         paddr[CFG_AW-1:2], want_reg, prdata));
      end
      if (out_mon.valid && out_mon.ready) begin
        seen = {out_mon.output_enable, out_mon.led_green, out_mon.led_orange,
                out_mon.led_red, out_mon.busy_res, out_mon.minutes_left,
                out_mon.event_res, out_mon.event_minutes};
        if (session_q.size() == 0) begin
          flag($sformatf("unexpected result beat: %s", show(seen)));
        end else begin
          want = session_q.pop_front();
          if (seen !== want)
            flag($sformatf("result mismatch at %0t\n  exp %s\n  got %s",
                           $realtime, show(want), show(seen)));
        end
      end
      if (in_mon.valid && in_mon.ready)
        session_q.push_back(session_result(in_mon.action, in_mon.lock_closed,
                                           in_mon.duration_min, in_mon.report_mode,
                                           in_mon.call_failed));
    end
    pending  <= session_q.size();
    fail_cnt <= errs;
  end

endmodule

FILE: tb/sv/tb_timed_locked_session_controller.sv
// tb_timed_locked_session_controller: drives directed and random session traffic and
// register settings into the session controller; depends on tlsc_pkg, the channel
// interfaces, the controller and tlsc_checker, which predicts and compares
module tb_timed_locked_session_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import tlsc_pkg::*;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 1456;
  localparam int PHASES       = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fail_cnt;
  int pending;
  int items_sent  = 0;
  int snd_calm    = 0;
  int rcv_calm    = 0;
  int idle_cycles = 0;
  bit rush        = 1'b0;

  tlsc_in_if  in_ch ();
  tlsc_out_if out_ch ();

  timed_locked_session_controller dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tlsc_checker chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_ch),
    .out_mon  (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .fail_cnt (fail_cnt),
    .pending  (pending)
  );

  always #1 clk = ~clk;

  function automatic int pick_wait(inout int calm);
    if (rush) return 0;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 60);
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [31:0] pick_reg();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  task automatic send(logic [1:0] act, logic lk, logic [15:0] dur, logic rep, logic fail);
    int gap;
    gap = pick_wait(snd_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.lock_closed  <= lk;
    in_ch.duration_min <= dur;
    in_ch.report_mode  <= rep;
    in_ch.call_failed  <= fail;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic tick(logic lk);
    send(ACT_TICK, lk, 16'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_access(logic wr, logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_regs(logic [31:0] lw, logic [31:0] gr, logic [31:0] hw);
    reg_access(1'b1, REG_LOCK_WAIT, lw);
    reg_access(1'b1, REG_UNLOCK_GRACE, gr);
    reg_access(1'b1, REG_HANGUP_WAIT, hw);
    if ($urandom_range(0, 1) == 0) reg_access(1'b1, NUM_REGS, $urandom);
    reg_access(1'b0, REG_LOCK_WAIT, '0);
    reg_access(1'b0, REG_UNLOCK_GRACE, '0);
    reg_access(1'b0, REG_HANGUP_WAIT, '0);
  endtask

  task automatic run_session();
    logic [15:0] dur;
    int          n;
    int          lean;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: dur = '0;
      5, 6, 7:       dur = 16'($urandom_range(1, 3));
      default:       dur = 16'($urandom);
    endcase
    send(ACT_START, 1'($urandom), dur, 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 6)) tick($urandom_range(0, 3) == 0);
    lean = $urandom_range(0, 3);
    n = $urandom_range(0, 30);
    repeat (n) begin
      if ($urandom_range(0, 40) == 0)
        send(ACT_STOP, 1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      else
        tick($urandom_range(0, 3) >= lean);
    end
    if ($urandom_range(0, 2) == 0)
      send(ACT_STOP, 1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    send(ACT_CALL, 1'($urandom), 16'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) == 0)
      send(ACT_CALL, 1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 24)) tick(1'($urandom));
  endtask

  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = pick_wait(rcv_calm);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL timed_locked_session_controller");
      $finish;
    end
  end

  initial begin
    int   quota;
    int   zeros;
    logic lk;
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_TICK;
    in_ch.lock_closed  <= 1'b0;
    in_ch.duration_min <= '0;
    in_ch.report_mode  <= 1'b0;
    in_ch.call_failed  <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, then short timeouts for the directed part
    reg_access(1'b0, REG_LOCK_WAIT, '0);
    reg_access(1'b0, REG_UNLOCK_GRACE, '0);
    reg_access(1'b0, REG_HANGUP_WAIT, '0);
    load_regs(32'd5, 32'd3, 32'd4);

    // commands while idle are ignored
    send(ACT_STOP, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    send(ACT_CALL, 1'b1, 16'h0000, 1'b0, 1'b0);
    // longest duration, reload while waiting for the lock, then stop while working
    send(ACT_START, 1'b0, 16'hFFFF, 1'b1, 1'b0);
    tick(1'b0);
    send(ACT_START, 1'b0, 16'h8000, 1'b0, 1'b1);
    tick(1'b1);
    tick(1'b0);
    send(ACT_STOP, 1'b1, 16'h0000, 1'b0, 1'b0);
    // zero duration: immediate report, then immediate call
    send(ACT_START, 1'b1, 16'h0000, 1'b1, 1'b0);
    send(ACT_START, 1'b1, 16'h0000, 1'b0, 1'b0);
    send(ACT_STOP, 1'b1, 16'h0000, 1'b0, 1'b0);
    tick(1'b1);
    send(ACT_CALL, 1'b0, 16'h0000, 1'b0, 1'b1);
    // successful call, hang-up after the wait
    send(ACT_START, 1'b1, 16'h0000, 1'b0, 1'b0);
    send(ACT_CALL, 1'b0, 16'hFFFF, 1'b1, 1'b0);
    repeat (4) tick(1'b0);
    // lock never closes
    send(ACT_START, 1'b0, 16'd1, 1'b0, 1'b0);
    repeat (5) tick(1'b0);
    // lock opens for the whole grace time
    send(ACT_START, 1'b1, 16'd1, 1'b1, 1'b0);
    repeat (3) tick(1'b0);
    // stop while waiting for the lock
    send(ACT_START, 1'b0, 16'd1, 1'b1, 1'b0);
    send(ACT_STOP, 1'b1, 16'd1, 1'b1, 1'b0);
    settle();

    // two-minute session, lock opening briefly now and then, ended by stop
    load_regs(32'd10, 32'd7, 32'd3);
    rush = 1'b1;
    send(ACT_START, 1'b1, 16'd2, 1'b1, 1'b0);
    zeros = 0;
    repeat (200) begin
      lk = 1'b1;
      if (zeros > 0) begin
        zeros--;
        lk = 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        zeros = $urandom_range(1, 5);
      end
      tick(lk);
    end
    send(ACT_STOP, 1'b1, 16'd0, 1'b0, 1'b0);
    settle();
    rush = 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)      load_regs('0, '0, '0);
      else if (p == 1) load_regs('1, '1, '1);
      else             load_regs(pick_reg(), pick_reg(), pick_reg());
      quota = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < quota) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 4))
            send(2'($urandom), 1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
        else
          run_session();
      end
      settle();
    end

    repeat (4) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("PASS timed_locked_session_controller");
    end else begin
      $display("FAIL timed_locked_session_controller");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tlsc_pkg.sv
rtl/tlsc_in_if.sv
rtl/tlsc_out_if.sv
rtl/timed_locked_session_controller.sv
rtl/tlsc_checker.sv
tb/sv/tlsc_checker.sv
tb/sv/tb_timed_locked_session_controller.sv
